/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* src/dpts_pkg.sv */
// ----------------------------------------------------------------------------
// dpts_pkg
// Types, codes and sizes shared by the task scheduler modules.
// ----------------------------------------------------------------------------
package dpts_pkg;

  // Table and field sizes
  localparam int MAX_TASKS = 32;
  localparam int IDX_BITS  = $clog2(MAX_TASKS);
  localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
  localparam int PRIO_BITS = 16;
  localparam int TIME_BITS = 64;
  localparam int MASK_BITS = 32;

  // Request modes
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_NEXT = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;

  // Response status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  // Request item
  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        task_time;
    logic signed [15:0] task_priority;
    logic [31:0]        depends_on;
    logic [63:0]        current_time;
    logic [5:0]         task_index;
  } req_t;

  // Response item
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] result_index;
    logic [5:0] pending_count;
  } rsp_t;

  // One task table entry
  typedef struct packed {
    logic [TIME_BITS-1:0]        release_time;
    logic signed [PRIO_BITS-1:0] prio;
    logic [MASK_BITS-1:0]        wait_mask;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic commit;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic scan_last;
    logic table_empty;
  } sts_t;

endpackage

/* src/dpts_ram.sv */
// ----------------------------------------------------------------------------
// dpts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/dpts_dp.sv */
// ----------------------------------------------------------------------------
// dpts_dp
// Scheduler datapath: task table, flags, pending count, scan and output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpts_dp (
  input  logic           clk,
  input  logic           rst,
  input  dpts_pkg::req_t req,
  input  dpts_pkg::cmd_t cmd,
  output dpts_pkg::sts_t sts,
  output dpts_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);

  logic [dpts_pkg::CNT_BITS-1:0]  task_count;
  logic [dpts_pkg::MAX_TASKS-1:0] done_flags;
  logic [dpts_pkg::MAX_TASKS-1:0] running_flags;
  logic [dpts_pkg::CNT_BITS-1:0]  pending;

  logic [dpts_pkg::TIME_BITS-1:0] now;
  logic [1:0]                     status;
  logic [dpts_pkg::IDX_BITS-1:0]  index;

  logic [dpts_pkg::IDX_BITS-1:0]  scan_addr;
  logic [dpts_pkg::IDX_BITS-1:0]  eval_idx;
  logic                           rd_pend;
  logic                           found;
  logic [dpts_pkg::IDX_BITS-1:0]  best_idx;
  logic signed [dpts_pkg::PRIO_BITS-1:0] best_prio;

  dpts_pkg::entry_t wr_entry;
  dpts_pkg::entry_t rd_entry;
  logic             full;
  logic             wr_en;
  logic             idx_bad;
  logic [dpts_pkg::IDX_BITS-1:0] cidx;
  logic             eval_ready;
  logic             eval_wins;

  assign full  = (task_count == dpts_pkg::CNT_BITS'(dpts_pkg::MAX_TASKS));
  assign wr_en = cmd.accept && (req.mode == dpts_pkg::MODE_ADD) && !full;
  assign idx_bad = ({1'b0, req.task_index} >= (dpts_pkg::CNT_BITS + 1)'(task_count));
  assign cidx    = req.task_index[dpts_pkg::IDX_BITS-1:0];

  // Pack a new table entry from the request
  always_comb begin
    wr_entry.release_time = req.task_time[dpts_pkg::TIME_BITS-1:0];
    wr_entry.prio         = req.task_priority[dpts_pkg::PRIO_BITS-1:0];
    wr_entry.wait_mask    = req.depends_on;
  end

  dpts_ram #(
    .WIDTH ($bits(dpts_pkg::entry_t)),
    .DEPTH (dpts_pkg::MAX_TASKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (task_count[dpts_pkg::IDX_BITS-1:0]),
    .wr_data (wr_entry),
    .rd_addr (scan_addr),
    .rd_data (rd_entry)
  );

  // Readiness and priority compare for the entry coming out of the table
  assign eval_ready = !done_flags[eval_idx] && !running_flags[eval_idx]
                    && (now >= rd_entry.release_time)
                    && ((rd_entry.wait_mask & ~done_flags) == '0);
  assign eval_wins  = eval_ready && (!found || (rd_entry.prio > best_prio));

  // Table count, flags and pending count
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count    <= '0;
      done_flags    <= '0;
      running_flags <= '0;
      pending       <= '0;
    end else if (cmd.accept) begin
      if (wr_en) begin
        task_count <= task_count + 1'b1;
        pending    <= pending + 1'b1;
        done_flags[task_count[dpts_pkg::IDX_BITS-1:0]]    <= 1'b0;
        running_flags[task_count[dpts_pkg::IDX_BITS-1:0]] <= 1'b0;
      end else if ((req.mode == dpts_pkg::MODE_DONE) && !idx_bad) begin
        done_flags[cidx]    <= 1'b1;
        running_flags[cidx] <= 1'b0;
        if (!done_flags[cidx]) begin
          pending <= pending - 1'b1;
        end
      end
    end else if (cmd.commit && found) begin
      running_flags[best_idx] <= 1'b1;
    end
  end

  // Latch the request outcome, then settle it at the end of a scan
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now   <= req.current_time[dpts_pkg::TIME_BITS-1:0];
      index <= '0;
      case (req.mode)
        dpts_pkg::MODE_ADD: begin
          status <= full ? dpts_pkg::ST_FULL : dpts_pkg::ST_OK;
          if (!full) begin
            index <= task_count[dpts_pkg::IDX_BITS-1:0];
          end
        end
        dpts_pkg::MODE_NEXT: status <= dpts_pkg::ST_NONE;
        dpts_pkg::MODE_DONE: status <= idx_bad ? dpts_pkg::ST_BADIDX : dpts_pkg::ST_OK;
        default:             status <= dpts_pkg::ST_OK;
      endcase
    end else if (cmd.commit) begin
      status <= found ? dpts_pkg::ST_OK : dpts_pkg::ST_NONE;
      index  <= found ? best_idx : '0;
    end
  end

  // Walk the table one entry a cycle and keep the best candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      found   <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_step;
      if (cmd.accept) begin
        found <= 1'b0;
      end else if (rd_pend && eval_wins) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_addr <= '0;
    end else if (cmd.scan_step) begin
      scan_addr <= scan_addr + 1'b1;
    end
    eval_idx <= scan_addr;
    if (rd_pend && eval_wins) begin
      best_idx  <= eval_idx;
      best_prio <= rd_entry.prio;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.status        <= status;
      rsp.result_index  <= index;
      rsp.pending_count <= pending;
    end
  end

  // Status back to the controller
  assign sts.out_free    = !rsp_valid || !rsp_stall;
  assign sts.scan_last   = ({1'b0, scan_addr} == (task_count - 1'b1));
  assign sts.table_empty = (task_count == '0);

  `ASSERT_ALWAYS(a_pending_bound, clk, rst, pending <= task_count, "pending above task count")
  `ASSERT_ALWAYS(a_done_not_running, clk, rst, (done_flags & running_flags) == '0, "task both done and running")
  `ASSERT_ALWAYS(a_flags_in_table, clk, rst, ((done_flags | running_flags) >> task_count) == '0, "flag set beyond table")

endmodule

/* src/dpts_ctrl.sv */
// ----------------------------------------------------------------------------
// dpts_ctrl
// Scheduler controller: sequences accept, table scan, commit and response.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic [1:0]     req_mode,
  output logic           req_stall,
  input  dpts_pkg::sts_t sts,
  output dpts_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd.accept    = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.commit    = 1'b0;
    cmd.load_out  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          if ((req_mode == dpts_pkg::MODE_NEXT) && !sts.table_empty) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_COMMIT;
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_IMPLIES(a_scan_nonempty, clk, rst, state == S_SCAN, !sts.table_empty, "scan of empty table")
  `ASSERT_IMPLIES(a_commit_after_drain, clk, rst, state == S_COMMIT, $past(state) == S_DRAIN, "commit out of order")

endmodule

/* src/dependency_priority_task_scheduler.sv */
// ----------------------------------------------------------------------------
// dependency_priority_task_scheduler
// Priority task scheduler with per-task dependency masks.
//
// Requests enter on req / req_valid / req_stall, responses leave on
// rsp / rsp_valid / rsp_stall; an item moves when valid is high and stall low.
// One request is worked at a time, and each gives exactly one response.
// Add, complete and unused modes: the response is loaded into the output
// register once that register is free, and the block then takes a new request.
// Next: the task table RAM is read one entry a cycle, then the controller
// passes through its drain and commit states before the response is loaded;
// an empty table answers like an add.
// The output register holds a response while rsp_stall is high; a finished
// request waits in the controller until that register frees up, and req_stall
// stays high meanwhile. Reset empties the table, clears all done and running
// flags and drops any pending response. Table entries need no clearing.
// ----------------------------------------------------------------------------
module dependency_priority_task_scheduler (
  input  logic           clk,
  input  logic           rst,
  input  dpts_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_stall,
  output dpts_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);

  dpts_pkg::cmd_t cmd;
  dpts_pkg::sts_t sts;

  dpts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req.mode),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dpts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dependency-aware priority task scheduler.
// A directed sequence covers table extremes, pick order, dependencies and
// completion corner cases. Shaped random traffic then fills the table and
// keeps it busy. Both handshake sides idle at random. Each response item is
// checked against an in-bench copy of the task table.
// ----------------------------------------------------------------------------
module tb_top;

  // Code for the mode that does nothing
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         CYCLE_LIMIT = 500_000;
  localparam int         ITEM_TARGET = 650;
  localparam int         IDLE_PCT    = 37;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  dpts_pkg::req_t req       = '0;
  logic           req_valid = 1'b0;
  logic           req_stall;
  dpts_pkg::rsp_t rsp;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;

  // Shadow task table
  int                 n_tasks;
  logic [63:0]        tbl_release [dpts_pkg::MAX_TASKS];
  logic signed [15:0] tbl_prio    [dpts_pkg::MAX_TASKS];
  logic [31:0]        tbl_deps    [dpts_pkg::MAX_TASKS];
  logic [31:0]        done_mask;
  logic [31:0]        run_mask;

  dpts_pkg::rsp_t rsp_due [$];
  int             err_count;
  int             items_sent;
  int             status_seen [4];
  int             cycle_count;
  bit             steady;
  logic [63:0]    now_ms;

  dependency_priority_task_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow table and return the response it owes
  function automatic dpts_pkg::rsp_t sched_step(dpts_pkg::req_t r);
    dpts_pkg::rsp_t o;
    int             best;
    bit             found;
    int             cnt;
    o = '0;
    o.status = dpts_pkg::ST_OK;
    best = 0;
    found = 1'b0;
    cnt = 0;
    case (r.mode)
      dpts_pkg::MODE_ADD: begin
        if (n_tasks >= dpts_pkg::MAX_TASKS) begin
          o.status = dpts_pkg::ST_FULL;
        end else begin
          tbl_release[n_tasks] = r.task_time;
          tbl_prio[n_tasks]    = r.task_priority;
          tbl_deps[n_tasks]    = r.depends_on;
          done_mask[n_tasks]   = 1'b0;
          run_mask[n_tasks]    = 1'b0;
          o.result_index       = n_tasks[4:0];
          n_tasks++;
        end
      end
      dpts_pkg::MODE_NEXT: begin
        // Done bits above the task count are always clear, so absent deps block
        for (int i = 0; i < n_tasks; i++) begin
          if (!done_mask[i] && !run_mask[i] && r.current_time >= tbl_release[i] &&
              (tbl_deps[i] & ~done_mask) == 32'd0) begin
            if (!found || tbl_prio[i] > tbl_prio[best]) begin
              best  = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          run_mask[best] = 1'b1;
          o.result_index = best[4:0];
        end else begin
          o.status = dpts_pkg::ST_NONE;
        end
      end
      dpts_pkg::MODE_DONE: begin
        if (r.task_index >= n_tasks) begin
          o.status = dpts_pkg::ST_BADIDX;
        end else begin
          done_mask[r.task_index] = 1'b1;
          run_mask[r.task_index]  = 1'b0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n_tasks; i++) begin
      if (!done_mask[i]) cnt++;
    end
    o.pending_count = cnt[5:0];
    return o;
  endfunction

  // Random background for every field, so unused fields toggle too
  function automatic dpts_pkg::req_t noise_item(logic [1:0] m);
    dpts_pkg::req_t r;
    r.mode          = m;
    r.task_time     = {$urandom, $urandom};
    r.task_priority = 16'($urandom);
    r.depends_on    = $urandom;
    r.current_time  = {$urandom, $urandom};
    r.task_index    = 6'($urandom_range(63));
    return r;
  endfunction

  function automatic int some_running();
    int start;
    start = $urandom_range(dpts_pkg::MAX_TASKS - 1);
    for (int k = 0; k < dpts_pkg::MAX_TASKS; k++) begin
      if (run_mask[(start + k) % dpts_pkg::MAX_TASKS]) begin
        return (start + k) % dpts_pkg::MAX_TASKS;
      end
    end
    return -1;
  endfunction

  // Build a request with content biased toward reachable schedules
  function automatic dpts_pkg::req_t shaped_item(logic [1:0] m);
    dpts_pkg::req_t r;
    int             roll;
    int             pick;
    logic [63:0]    lower;
    r = noise_item(m);
    now_ms += $urandom_range(40);
    roll = $urandom_range(19);
    case (m)
      dpts_pkg::MODE_ADD: begin
        if (roll == 1) r.task_time = '0;
        else if (roll > 2) r.task_time = now_ms + $urandom_range(400);
        if ($urandom_range(1)) r.task_priority = 16'($urandom_range(15) - 8);
        lower = (64'd1 << n_tasks) - 64'd1;
        roll = $urandom_range(9);
        if (roll == 1) r.depends_on = '0;
        else if (roll > 1) r.depends_on = $urandom & $urandom & $urandom & lower[31:0];
      end
      dpts_pkg::MODE_NEXT: begin
        if (roll == 2) r.current_time = '0;
        else if (roll > 2) r.current_time = now_ms;
      end
      dpts_pkg::MODE_DONE: begin
        pick = some_running();
        if (roll < 9 && pick >= 0) r.task_index = 6'(pick);
        else if (roll < 16 && n_tasks > 0) r.task_index = 6'($urandom_range(n_tasks - 1));
      end
      default: ;
    endcase
    return r;
  endfunction

  // Present one item, wait for acceptance, record what it owes
  task automatic send_item(dpts_pkg::req_t item);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    // Stall is steady between edges; the item moves at the next rising edge
    @(negedge clk);
    while (req_stall) @(negedge clk);
    @(posedge clk);
    rsp_due.push_back(sched_step(item));
    items_sent++;
  endtask

  task automatic add_task(logic [63:0] t, logic signed [15:0] p, logic [31:0] d);
    dpts_pkg::req_t r;
    r = noise_item(dpts_pkg::MODE_ADD);
    r.task_time     = t;
    r.task_priority = p;
    r.depends_on    = d;
    send_item(r);
  endtask

  task automatic pick_next(logic [63:0] t_now);
    dpts_pkg::req_t r;
    r = noise_item(dpts_pkg::MODE_NEXT);
    r.current_time = t_now;
    send_item(r);
  endtask

  task automatic finish_task(logic [5:0] idx);
    dpts_pkg::req_t r;
    r = noise_item(dpts_pkg::MODE_DONE);
    r.task_index = idx;
    send_item(r);
  endtask

  // Nothing to pick and nothing to complete in an empty table
  task automatic test_empty_table();
    pick_next('0);
    finish_task(6'd0);
  endtask

  task automatic test_unused_mode();
    send_item(noise_item(MODE_SPARE));
  endtask

  // Priority and time extremes, absent and self dependencies
  task automatic test_add_extremes();
    add_task('0, 16'sh7FFF, '0);
    add_task('1, 16'sh8000, '0);
    add_task(64'd5, 16'sh8000, 32'hFFFF_FFFF);
    add_task('0, 16'sh0000, 32'h0000_0008);
    add_task(64'd10, 16'sd100, 32'h0000_0001);
    add_task('0, 16'sh7FFF, '0);
  endtask

  // Tie to lowest index, then release time and dependency blocking
  task automatic test_pick_order();
    pick_next('0);
    pick_next('0);
    pick_next('0);
    pick_next(64'd9);
  endtask

  // Completion of running, done, never-picked and out-of-range tasks
  task automatic test_completion();
    finish_task(6'd0);
    pick_next(64'd10);
    finish_task(6'd0);
    finish_task(6'd1);
    finish_task(6'd63);
    finish_task(6'd6);
    pick_next('1);
    finish_task(6'd5);
  endtask

  // Mixed traffic weighted toward adds until the table is full
  task automatic test_fill_table();
    int roll;
    while (n_tasks < dpts_pkg::MAX_TASKS) begin
      roll = $urandom_range(99);
      if (roll < 50) send_item(shaped_item(dpts_pkg::MODE_ADD));
      else if (roll < 80) send_item(shaped_item(dpts_pkg::MODE_NEXT));
      else if (roll < 95) send_item(shaped_item(dpts_pkg::MODE_DONE));
      else send_item(shaped_item(MODE_SPARE));
    end
  endtask

  // Full-table traffic, with a stretch where neither side idles
  task automatic test_random_traffic();
    int roll;
    int k;
    k = 0;
    while (items_sent < ITEM_TARGET) begin
      steady = (k >= 150 && k < 260);
      roll = $urandom_range(99);
      if (roll < 15) send_item(shaped_item(dpts_pkg::MODE_ADD));
      else if (roll < 60) send_item(shaped_item(dpts_pkg::MODE_NEXT));
      else if (roll < 90) send_item(shaped_item(dpts_pkg::MODE_DONE));
      else send_item(shaped_item(MODE_SPARE));
      k++;
    end
    steady = 1'b0;
  endtask

  // Stall responses at random
  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // Check each accepted response against the oldest owed one
  always @(posedge clk) begin : check_rsp
    dpts_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        $error("response with none owed: status %0d index %0d pending %0d",
               rsp.status, rsp.result_index, rsp.pending_count);
        err_count++;
      end else begin
        want = rsp_due.pop_front();
        status_seen[want.status]++;
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          err_count++;
        end
        if (rsp.result_index !== want.result_index) begin
          $error("result_index: expected %0d, got %0d", want.result_index,
                 rsp.result_index);
          err_count++;
        end
        if (rsp.pending_count !== want.pending_count) begin
          $error("pending_count: expected %0d, got %0d", want.pending_count,
                 rsp.pending_count);
          err_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int sched_pending();
    int cnt;
    cnt = 0;
    for (int i = 0; i < n_tasks; i++) begin
      if (!done_mask[i]) cnt++;
    end
    return cnt;
  endfunction

  initial begin
    n_tasks     = 0;
    done_mask   = '0;
    run_mask    = '0;
    err_count   = 0;
    items_sent  = 0;
    cycle_count = 0;
    steady      = 1'b0;
    now_ms      = '0;
    foreach (status_seen[s]) status_seen[s] = 0;

    // Hold reset, then run the tests in turn
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_unused_mode();
    test_add_extremes();
    test_pick_order();
    test_completion();
    test_fill_table();
    test_random_traffic();
    req_valid <= 1'b0;

    // Drain owed responses, then watch for strays
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d items over %0d cycles; %0d tasks added, %0d still pending.",
             items_sent, cycle_count, n_tasks, sched_pending());
    $display("Responses: %0d ok, %0d table full, %0d nothing ready, %0d bad index.",
             status_seen[dpts_pkg::ST_OK], status_seen[dpts_pkg::ST_FULL],
             status_seen[dpts_pkg::ST_NONE], status_seen[dpts_pkg::ST_BADIDX]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/dpts_pkg.sv
src/dpts_ram.sv
src/dpts_dp.sv
src/dpts_ctrl.sv
src/dependency_priority_task_scheduler.sv
verif/tb_top.sv
